// ===== rtl/audio_noise_gate_assert.svh =====
// ----------------------------------------------------------------------------
// audio_noise_gate assertion macros
// Shared concurrent assertion forms used by the noise gate RTL.
// ----------------------------------------------------------------------------
`ifndef AUDIO_NOISE_GATE_ASSERT_SVH
`define AUDIO_NOISE_GATE_ASSERT_SVH

// Condition that must hold in the same cycle as the trigger.
`define ANG_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("audio_noise_gate: same-cycle assertion failed");

// Condition that must hold in the cycle after the trigger.
`define ANG_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("audio_noise_gate: next-cycle assertion failed");

`endif

// ===== rtl/ang_pkg.sv =====
// ----------------------------------------------------------------------------
// ang_pkg
// Widths, constants and payload types of the audio noise gate.
// ----------------------------------------------------------------------------
package ang_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int COEFF_BITS     = 16;
    localparam int THRESH_BITS    = 15;
    localparam int ENV_W          = GAIN_FRAC_BITS + 1;

    // Operand width of the shared multiplier: wide enough for every use.
    localparam int MUL_W_A = (SAMPLE_BITS > ENV_W) ? SAMPLE_BITS : ENV_W;
    localparam int MUL_W   = (MUL_W_A > COEFF_BITS) ? MUL_W_A : COEFF_BITS;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic [ENV_W-1:0] ENV_ONE  = ENV_W'(1) << GAIN_FRAC_BITS;
    localparam logic [ENV_W-1:0] ENV_HALF = ENV_W'(1) << (GAIN_FRAC_BITS - 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET  = THRESH_BITS'(328);
    localparam logic [COEFF_BITS-1:0]  ATTACK_RESET  = COEFF_BITS'(655);
    localparam logic [COEFF_BITS-1:0]  RELEASE_RESET = COEFF_BITS'(66);

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_ATTACK    = 2'd1,
        REG_RELEASE   = 2'd2,
        REG_SPARE     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_start;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          gate_is_open;
        logic                          gate_toggled;
    } t_out;

    typedef struct packed {
        logic [THRESH_BITS-1:0] threshold_level;
        logic [COEFF_BITS-1:0]  attack_coeff;
        logic [COEFF_BITS-1:0]  release_coeff;
    } t_cfg;

endpackage

// ===== rtl/ang_regs.sv =====
// ----------------------------------------------------------------------------
// ang_regs
// APB-style configuration registers: threshold, attack and release.
// ----------------------------------------------------------------------------
module ang_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ang_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ang_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ang_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output ang_pkg::t_cfg                    o_cfg
);

    ang_pkg::t_cfg     r_cfg;
    logic              wr_en;
    ang_pkg::t_reg_idx reg_idx;

    assign reg_idx = ang_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_level <= ang_pkg::THRESH_RESET;
            r_cfg.attack_coeff    <= ang_pkg::ATTACK_RESET;
            r_cfg.release_coeff   <= ang_pkg::RELEASE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                ang_pkg::REG_THRESHOLD: begin
                    r_cfg.threshold_level <= pwdata[ang_pkg::THRESH_BITS-1:0];
                end
                ang_pkg::REG_ATTACK: begin
                    r_cfg.attack_coeff <= pwdata[ang_pkg::COEFF_BITS-1:0];
                end
                ang_pkg::REG_RELEASE: begin
                    r_cfg.release_coeff <= pwdata[ang_pkg::COEFF_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ang_pkg::REG_THRESHOLD:
                prdata = ang_pkg::APB_DATA_W'(r_cfg.threshold_level);
            ang_pkg::REG_ATTACK:
                prdata = ang_pkg::APB_DATA_W'(r_cfg.attack_coeff);
            ang_pkg::REG_RELEASE:
                prdata = ang_pkg::APB_DATA_W'(r_cfg.release_coeff);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== rtl/ang_mul.sv =====
// ----------------------------------------------------------------------------
// ang_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ang_mul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [ang_pkg::MUL_W-1:0]     i_a,
    input  logic [ang_pkg::MUL_W-1:0]     i_b,
    output logic [ang_pkg::PROD_W-1:0]    o_prod
);

    logic [ang_pkg::PROD_W-1:0] r_prod;
    logic [ang_pkg::PROD_W-1:0] n_prod;

    assign n_prod = ang_pkg::PROD_W'(i_a) * ang_pkg::PROD_W'(i_b);
    assign o_prod = r_prod;

    // The product holds while disabled, so a stalled result stays readable.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

endmodule

// ===== rtl/audio_noise_gate.sv =====
// Each accepted sample passes the update, gain and load states in order;
// no new sample is taken until its result is loaded into the output. The
// shared multiplier is used twice per sample (envelope step, then sample
// times envelope). A new sample is taken while the previous result still
// waits in the output. Reset clears the envelope and gate state to zero
// (closed) and loads the default threshold, attack and release values.
// ----------------------------------------------------------------------------
// audio_noise_gate
// Noise gate with an attack/release gain envelope and a shared multiplier.
// ----------------------------------------------------------------------------
module audio_noise_gate (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ang_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ang_pkg::t_out                    o_out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ang_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ang_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ang_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    `include "audio_noise_gate_assert.svh"

    localparam int SB = ang_pkg::SAMPLE_BITS;
    localparam int EW = ang_pkg::ENV_W;
    localparam int CB = ang_pkg::COEFF_BITS;
    localparam int SUM_W = CB + EW + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_GAIN = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    ang_pkg::t_cfg cfg;

    t_state               r_state, n_state;
    logic [EW-1:0]        r_env;
    logic                 r_gate;
    logic [SB-1:0]        r_mag;
    logic                 r_neg;
    logic                 r_open;
    logic                 r_out_valid;
    ang_pkg::t_out        r_out;

    logic                 in_acc;
    logic                 load_out;
    logic [SB-1:0]        in_mag;
    logic                 in_neg;
    logic                 in_open;
    logic [EW-1:0]        env_cur;
    logic [EW-1:0]        env_dist;
    logic [CB-1:0]        coeff;
    logic                 mul_en;
    logic [ang_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [ang_pkg::PROD_W-1:0] prod;
    logic [SUM_W-1:0]     step_sum;
    logic [SUM_W-CB-1:0]  step;
    logic [EW:0]          env_up;
    logic [EW-1:0]        n_env;
    logic [SB-1:0]        res_mag;
    logic                 now_open;

    ang_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign load_out   = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    // Magnitude is exact for the most negative sample when read as unsigned.
    assign in_neg   = i_in_data.sample_in[SB-1];
    assign in_mag   = in_neg ? SB'(-i_in_data.sample_in) : SB'(i_in_data.sample_in);
    assign in_open  = in_mag >= SB'(cfg.threshold_level);
    assign env_cur  = i_in_data.block_start ? '0 : r_env;
    assign env_dist = in_open ? (ang_pkg::ENV_ONE - env_cur) : env_cur;
    assign coeff    = in_open ? cfg.attack_coeff : cfg.release_coeff;

    always_comb begin
        if (r_state == S_IDLE) begin
            mul_a = ang_pkg::MUL_W'(coeff);
            mul_b = ang_pkg::MUL_W'(env_dist);
        end else begin
            mul_a = ang_pkg::MUL_W'(r_mag);
            mul_b = ang_pkg::MUL_W'(r_env);
        end
    end

    assign mul_en = in_acc || (r_state == S_GAIN);

    ang_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Envelope step rounds up so that the envelope can settle on its target.
    assign step_sum = SUM_W'(prod[CB+EW-1:0]) + SUM_W'({CB{1'b1}});
    assign step     = step_sum[SUM_W-1:CB];
    assign env_up   = (EW+1)'(r_env) + (EW+1)'(step);

    always_comb begin
        if (r_open) begin
            n_env = (env_up > (EW+1)'(ang_pkg::ENV_ONE)) ? ang_pkg::ENV_ONE : env_up[EW-1:0];
        end else begin
            n_env = r_env - step[EW-1:0];
        end
    end

    assign res_mag  = prod[ang_pkg::GAIN_FRAC_BITS +: SB];
    assign now_open = r_env > ang_pkg::ENV_HALF;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc)   n_state = S_UPD;
            S_UPD:                n_state = S_GAIN;
            S_GAIN:               n_state = S_LOAD;
            S_LOAD: if (load_out) n_state = S_IDLE;
            default:              n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_env       <= '0;
            r_gate      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_env <= env_cur;
            end else if (r_state == S_UPD) begin
                r_env <= n_env;
            end
            if (load_out) begin
                r_gate      <= now_open;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mag  <= in_mag;
            r_neg  <= in_neg;
            r_open <= in_open;
        end
        if (load_out) begin
            r_out.sample_out   <= r_neg ? -res_mag : res_mag;
            r_out.gate_is_open <= now_open;
            r_out.gate_toggled <= now_open != r_gate;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ANG_ASSERT_SAME(a_env_limit, i_clk, i_rst_n, 1'b1, r_env <= ang_pkg::ENV_ONE)
    `ANG_ASSERT_NEXT(a_accept_seq, i_clk, i_rst_n, in_acc, r_state == S_UPD)
    `ANG_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, load_out, o_out_valid && o_in_ready)
    `ANG_ASSERT_SAME(a_gate_match, i_clk, i_rst_n, o_out_valid, o_out_data.gate_is_open == r_gate)

endmodule
